// ----- src/alu8_pkg.sv -----
package alu8_pkg;

  localparam int unsigned NIBBLE = 4;

  localparam logic [4:0] OP_ADD   = 5'd0;
  localparam logic [4:0] OP_ADC   = 5'd1;
  localparam logic [4:0] OP_SUB   = 5'd2;
  localparam logic [4:0] OP_SBC   = 5'd3;
  localparam logic [4:0] OP_AND   = 5'd4;
  localparam logic [4:0] OP_OR    = 5'd5;
  localparam logic [4:0] OP_XOR   = 5'd6;
  localparam logic [4:0] OP_CP    = 5'd7;
  localparam logic [4:0] OP_INC8  = 5'd8;
  localparam logic [4:0] OP_DEC8  = 5'd9;
  localparam logic [4:0] OP_INC16 = 5'd10;
  localparam logic [4:0] OP_DEC16 = 5'd11;
  localparam logic [4:0] OP_ADDHL = 5'd12;
  localparam logic [4:0] OP_CCF   = 5'd13;
  localparam logic [4:0] OP_SCF   = 5'd14;
  localparam logic [4:0] OP_CPL   = 5'd15;
  localparam logic [4:0] OP_RLCA  = 5'd16;
  localparam logic [4:0] OP_RRCA  = 5'd17;
  localparam logic [4:0] OP_RLA   = 5'd18;
  localparam logic [4:0] OP_RRA   = 5'd19;
  localparam logic [4:0] OP_RLC   = 5'd20;
  localparam logic [4:0] OP_RRC   = 5'd21;
  localparam logic [4:0] OP_RL    = 5'd22;
  localparam logic [4:0] OP_RR    = 5'd23;
  localparam logic [4:0] OP_SLA   = 5'd24;
  localparam logic [4:0] OP_SRA   = 5'd25;
  localparam logic [4:0] OP_SRL   = 5'd26;
  localparam logic [4:0] OP_SWAP  = 5'd27;
  localparam logic [4:0] OP_BIT   = 5'd28;
  localparam logic [4:0] OP_RES   = 5'd29;
  localparam logic [4:0] OP_SET   = 5'd30;

  typedef struct packed {
    logic zero;
    logic subtract;
    logic half;
    logic carry;
  } flags_t;

endpackage

// ----- src/eight_bit_cpu_alu_with_flags.sv -----
// an accepted item is held in the input register; its result and done are then registered in the result register
// throughput: one item per cycle; busy is always low
// the input register and the result register are the only pipeline stages
// the receiver cannot stall, so done flags each result for exactly one cycle
// rst (synchronous, active high) clears the valid bits of both stages
module eight_bit_cpu_alu_with_flags
  import alu8_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [4:0]  action,
  input  logic [7:0]  acc_value,
  input  logic [7:0]  operand_value,
  input  logic [2:0]  bit_sel,
  input  logic [15:0] hl_value,
  input  logic [15:0] pair_value,
  input  logic        zero_in,
  input  logic        subtract_in,
  input  logic        half_in,
  input  logic        carry_in,
  output logic        done,
  output logic [15:0] result_value,
  output logic        writes_back,
  output logic        zero_out,
  output logic        subtract_out,
  output logic        half_out,
  output logic        carry_out
);

  logic        in_valid;
  logic [4:0]  act;
  logic [7:0]  a;
  logic [7:0]  v;
  logic [2:0]  bi;
  logic [15:0] hl;
  logic [15:0] pr;
  flags_t      fin;

  logic [15:0] res_next;
  logic        wb_next;
  flags_t      f_next;

  logic        cin;
  logic [8:0]  sum9;
  logic [4:0]  sum_lo;
  logic [8:0]  diff9;
  logic [4:0]  diff_lo;
  logic [16:0] sum17;
  logic [12:0] sum13;
  logic [7:0]  mask;
  logic [7:0]  r8;
  logic        sh_c;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      in_valid <= start & ~busy;
      done     <= in_valid;
    end
    if (start & ~busy) begin
      act <= action;
      a   <= acc_value;
      v   <= operand_value;
      bi  <= bit_sel;
      hl  <= hl_value;
      pr  <= pair_value;
      fin <= '{zero: zero_in, subtract: subtract_in, half: half_in, carry: carry_in};
    end
    if (in_valid) begin
      result_value <= res_next;
      writes_back  <= wb_next;
      zero_out     <= f_next.zero;
      subtract_out <= f_next.subtract;
      half_out     <= f_next.half;
      carry_out    <= f_next.carry;
    end
  end

  assign cin     = (act == OP_ADC || act == OP_SBC) ? fin.carry : 1'b0;
  assign sum9    = {1'b0, a} + {1'b0, v} + {8'd0, cin};
  assign sum_lo  = {1'b0, a[3:0]} + {1'b0, v[3:0]} + {4'd0, cin};
  assign diff9   = {1'b0, a} - {1'b0, v} - {8'd0, cin};
  assign diff_lo = {1'b0, a[3:0]} - {1'b0, v[3:0]} - {4'd0, cin};
  assign sum17   = {1'b0, hl} + {1'b0, pr};
  assign sum13   = {1'b0, hl[11:0]} + {1'b0, pr[11:0]};
  assign mask    = 8'd1 << bi;

  // shared rotate and shift unit
  always_comb begin
    r8   = 8'd0;
    sh_c = 1'b0;
    case (act)
      OP_RLCA, OP_RLC: begin
        r8 = (act == OP_RLCA) ? {a[6:0], a[7]} : {v[6:0], v[7]};
        sh_c = (act == OP_RLCA) ? a[7] : v[7];
      end
      OP_RRCA, OP_RRC: begin
        r8 = (act == OP_RRCA) ? {a[0], a[7:1]} : {v[0], v[7:1]};
        sh_c = (act == OP_RRCA) ? a[0] : v[0];
      end
      OP_RLA, OP_RL: begin
        r8 = (act == OP_RLA) ? {a[6:0], fin.carry} : {v[6:0], fin.carry};
        sh_c = (act == OP_RLA) ? a[7] : v[7];
      end
      OP_RRA, OP_RR: begin
        r8 = (act == OP_RRA) ? {fin.carry, a[7:1]} : {fin.carry, v[7:1]};
        sh_c = (act == OP_RRA) ? a[0] : v[0];
      end
      OP_SLA: begin
        r8 = {v[6:0], 1'b0};
        sh_c = v[7];
      end
      OP_SRA: begin
        r8 = {v[7], v[7:1]};
        sh_c = v[0];
      end
      OP_SRL: begin
        r8 = {1'b0, v[7:1]};
        sh_c = v[0];
      end
      default: begin
        r8   = 8'd0;
        sh_c = 1'b0;
      end
    endcase
  end

  always_comb begin
    res_next = 16'd0;
    wb_next  = 1'b1;
    f_next   = fin;
    case (act)
      OP_ADD, OP_ADC: begin
        res_next = {8'd0, sum9[7:0]};
        f_next   = '{zero: sum9[7:0] == 8'd0, subtract: 1'b0, half: sum_lo[4],
                     carry: sum9[8]};
      end
      OP_SUB, OP_SBC, OP_CP: begin
        res_next = {8'd0, diff9[7:0]};
        wb_next  = (act != OP_CP);
        f_next   = '{zero: diff9[7:0] == 8'd0, subtract: 1'b1, half: diff_lo[4],
                     carry: diff9[8]};
      end
      OP_AND: begin
        res_next = {8'd0, a & v};
        f_next   = '{zero: (a & v) == 8'd0, subtract: 1'b0, half: 1'b1, carry: 1'b0};
      end
      OP_OR: begin
        res_next = {8'd0, a | v};
        f_next   = '{zero: (a | v) == 8'd0, subtract: 1'b0, half: 1'b0, carry: 1'b0};
      end
      OP_XOR: begin
        res_next = {8'd0, a ^ v};
        f_next   = '{zero: (a ^ v) == 8'd0, subtract: 1'b0, half: 1'b0, carry: 1'b0};
      end
      OP_INC8: begin
        res_next = {8'd0, v + 8'd1};
        f_next   = '{zero: v == 8'hFF, subtract: 1'b0, half: v[3:0] == 4'hF,
                     carry: fin.carry};
      end
      OP_DEC8: begin
        res_next = {8'd0, v - 8'd1};
        f_next   = '{zero: v == 8'h01, subtract: 1'b1, half: v[3:0] == 4'h0,
                     carry: fin.carry};
      end
      OP_INC16: begin
        res_next = pr + 16'd1;
      end
      OP_DEC16: begin
        res_next = pr - 16'd1;
      end
      OP_ADDHL: begin
        res_next = sum17[15:0];
        f_next   = '{zero: fin.zero, subtract: 1'b0, half: sum13[12], carry: sum17[16]};
      end
      OP_CCF: begin
        wb_next = 1'b0;
        f_next  = '{zero: fin.zero, subtract: 1'b0, half: 1'b0, carry: ~fin.carry};
      end
      OP_SCF: begin
        wb_next = 1'b0;
        f_next  = '{zero: fin.zero, subtract: 1'b0, half: 1'b0, carry: 1'b1};
      end
      OP_CPL: begin
        res_next = {8'd0, ~a};
        f_next   = '{zero: fin.zero, subtract: 1'b1, half: 1'b1, carry: fin.carry};
      end
      OP_RLCA, OP_RRCA, OP_RLA, OP_RRA: begin
        res_next = {8'd0, r8};
        f_next   = '{zero: 1'b0, subtract: 1'b0, half: 1'b0, carry: sh_c};
      end
      OP_RLC, OP_RRC, OP_RL, OP_RR, OP_SLA, OP_SRA, OP_SRL: begin
        res_next = {8'd0, r8};
        f_next   = '{zero: r8 == 8'd0, subtract: 1'b0, half: 1'b0, carry: sh_c};
      end
      OP_SWAP: begin
        res_next = {8'd0, v[NIBBLE-1:0], v[7:NIBBLE]};
        f_next   = '{zero: v == 8'd0, subtract: 1'b0, half: 1'b0, carry: 1'b0};
      end
      OP_BIT: begin
        wb_next = 1'b0;
        f_next  = '{zero: (v & mask) == 8'd0, subtract: 1'b0, half: 1'b1,
                    carry: fin.carry};
      end
      OP_RES: begin
        res_next = {8'd0, v & ~mask};
      end
      OP_SET: begin
        res_next = {8'd0, v | mask};
      end
      default: begin
        wb_next = 1'b0;
      end
    endcase
  end

endmodule
